/* rtl/olda_pkg.sv */
// Package: shared types and codes for the one-lane direction arbiter.
`timescale 1ns / 1ps

package olda_pkg;

   localparam int ID_W    = 10;
   localparam int LIMIT_W = 4;
   localparam int COUNT_W = 4;
   localparam int WAIT_W  = 7;

   typedef enum logic [1:0] {
      DIR_FREE = 2'd0,
      DIR_NS   = 2'd1,
      DIR_SN   = 2'd2
   } dir_type;

   // Per-tick commands to one wait queue.
   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   // Per-tick commands to the shared section.
   typedef struct packed {
      logic leave;
      logic enter;
   } section_ctrl_type;

endpackage

/* rtl/one_lane_direction_arbiter.sv */
// Top level: one-lane direction arbiter with two wait queues and a shared section.
// A transaction taken on req_ is held in the input register and resolved into the result
// register, where rsp_valid rises, once that register is free or draining.
// Throughput: one transaction per cycle while rsp_ready is high.
// Reset (synchronous, active high) empties both queues and the section, frees the
// direction and sets section_limit to 3; queue contents are not cleared.
`timescale 1ns / 1ps

module one_lane_direction_arbiter
   import olda_pkg::*;
#(
   parameter int QUEUE_DEPTH   = 64,
   parameter int SECTION_SLOTS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [LIMIT_W-1:0]   csr_section_limit,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_arrival_valid,
   input  logic [ID_W-1:0]      req_arrival_id,
   input  logic                 req_arrival_dir,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_arrival_dropped,
   output logic                 rsp_exit_valid,
   output logic [ID_W-1:0]      rsp_exit_id,
   output logic                 rsp_enter_valid,
   output logic [ID_W-1:0]      rsp_enter_id,
   output logic [1:0]           rsp_section_dir,
   output logic [COUNT_W-1:0]   rsp_section_count,
   output logic [WAIT_W-1:0]    rsp_north_waiting,
   output logic [WAIT_W-1:0]    rsp_south_waiting
);

   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int CW = $clog2(SECTION_SLOTS + 1);
   localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

   logic [LIMIT_W-1:0] limit_ff;

   logic               in_valid_ff;
   logic               in_arr_valid_ff;
   logic [ID_W-1:0]    in_arr_id_ff;
   logic               in_arr_dir_ff;

   logic               out_valid_ff;
   logic               out_dropped_ff, out_exit_valid_ff, out_enter_valid_ff;
   logic [ID_W-1:0]    out_exit_id_ff, out_enter_id_ff;
   logic [1:0]         out_dir_ff;
   logic [COUNT_W-1:0] out_count_ff;
   logic [WAIT_W-1:0]  out_north_ff, out_south_ff;

   dir_type            dir_ff, dir_in, dir_left;
   logic               advance;

   queue_ctrl_type     north_ctrl, south_ctrl;
   section_ctrl_type   sec_ctrl;
   logic               north_ok, south_ok, north_avail, south_avail;
   logic [ID_W-1:0]    north_front, south_front, sec_front, enter_id;
   logic [FW-1:0]      north_fill, south_fill, north_fill_in, south_fill_in;
   logic [CW-1:0]      sec_count, count_left, count_in;
   logic [LW-1:0]      eff_limit;
   logic               room, take_north, take_south, dropped;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_W'(3);
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_section_limit;
      end
   end

   // Advance the input transaction when the result register is free or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_arr_valid_ff <= req_arrival_valid;
         in_arr_id_ff    <= req_arrival_id;
         in_arr_dir_ff   <= req_arrival_dir;
      end
   end

   olda_wait_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_north (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (north_ctrl),
      .push_id  (in_arr_id_ff),
      .push_ok  (north_ok),
      .avail    (north_avail),
      .front_id (north_front),
      .fill     (north_fill)
   );

   olda_wait_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_south (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (south_ctrl),
      .push_id  (in_arr_id_ff),
      .push_ok  (south_ok),
      .avail    (south_avail),
      .front_id (south_front),
      .fill     (south_fill)
   );

   olda_section #(.SECTION_SLOTS(SECTION_SLOTS)) u_section (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (sec_ctrl),
      .enter_id (enter_id),
      .front_id (sec_front),
      .count    (sec_count)
   );

   assign eff_limit = (LW'(limit_ff) > LW'(SECTION_SLOTS)) ? LW'(SECTION_SLOTS)
                                                            : LW'(limit_ff);

   always_comb begin
      north_ctrl.push = advance && in_arr_valid_ff && !in_arr_dir_ff;
      south_ctrl.push = advance && in_arr_valid_ff && in_arr_dir_ff;
      dropped = in_arr_valid_ff && (in_arr_dir_ff ? !south_ok : !north_ok);

      // Oldest item leaves; free the lane once the section runs empty.
      sec_ctrl.leave = advance && (sec_count != '0);
      count_left = CW'(sec_count - CW'(sec_ctrl.leave));
      dir_left = (sec_ctrl.leave && (count_left == '0)) ? DIR_FREE : dir_ff;

      room   = advance && (LW'(count_left) < eff_limit);
      dir_in = dir_left;
      if (room && (dir_left == DIR_FREE)) begin
         priority if (north_avail) begin
            dir_in = DIR_NS;
         end else if (south_avail) begin
            dir_in = DIR_SN;
         end else begin
            dir_in = DIR_FREE;
         end
      end

      take_north = room && (dir_in == DIR_NS) && north_avail;
      take_south = room && (dir_in == DIR_SN) && south_avail;
      north_ctrl.pop = take_north;
      south_ctrl.pop = take_south;
      sec_ctrl.enter = take_north || take_south;
      enter_id = take_north ? north_front : (take_south ? south_front : '0);

      count_in      = CW'(count_left + CW'(sec_ctrl.enter));
      north_fill_in = FW'(north_fill + FW'(north_ctrl.push && north_ok) - FW'(take_north));
      south_fill_in = FW'(south_fill + FW'(south_ctrl.push && south_ok) - FW'(take_south));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= DIR_FREE;
      end else if (advance) begin
         dir_ff <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_dropped_ff     <= dropped;
         out_exit_valid_ff  <= sec_ctrl.leave;
         out_exit_id_ff     <= sec_ctrl.leave ? sec_front : '0;
         out_enter_valid_ff <= sec_ctrl.enter;
         out_enter_id_ff    <= enter_id;
         out_dir_ff         <= 2'(dir_in);
         out_count_ff       <= COUNT_W'(count_in);
         out_north_ff       <= WAIT_W'(north_fill_in);
         out_south_ff       <= WAIT_W'(south_fill_in);
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_arrival_dropped = out_dropped_ff;
   assign rsp_exit_valid      = out_exit_valid_ff;
   assign rsp_exit_id         = out_exit_id_ff;
   assign rsp_enter_valid     = out_enter_valid_ff;
   assign rsp_enter_id        = out_enter_id_ff;
   assign rsp_section_dir     = out_dir_ff;
   assign rsp_section_count   = out_count_ff;
   assign rsp_north_waiting   = out_north_ff;
   assign rsp_south_waiting   = out_south_ff;

   a_lane_owned_iff_occupied: assert property (@(posedge clock) disable iff (reset)
      (sec_count == '0) == (dir_ff == DIR_FREE))
      else $error("section occupancy and lane direction disagree");

   a_section_bounded: assert property (@(posedge clock) disable iff (reset)
      sec_count <= CW'(SECTION_SLOTS))
      else $error("section holds more items than it has slots");

   a_queues_bounded: assert property (@(posedge clock) disable iff (reset)
      (north_fill <= FW'(QUEUE_DEPTH)) && (south_fill <= FW'(QUEUE_DEPTH)))
      else $error("wait queue fill beyond its depth");

   a_enter_owns_lane: assert property (@(posedge clock) disable iff (reset)
      sec_ctrl.enter |=> (dir_ff != DIR_FREE) && (sec_count != '0))
      else $error("entry left the lane free or the section empty");

   a_result_follows_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("resolved transaction produced no result");

endmodule

/* rtl/olda_wait_queue.sv */
// Circular wait queue with a registered (prefetched) head entry.
`timescale 1ns / 1ps

module olda_wait_queue
   import olda_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  queue_ctrl_type                     ctrl,
   input  logic [ID_W-1:0]                    push_id,
   output logic                               push_ok,
   output logic                               avail,
   output logic [ID_W-1:0]                    front_id,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   fill
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);

   logic [ID_W-1:0] mem [QUEUE_DEPTH];
   logic [PW-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic [ID_W-1:0] head_id_ff;
   logic            push_w;

   assign push_ok  = (fill_ff != FW'(QUEUE_DEPTH));
   assign push_w   = ctrl.push && push_ok;
   // An empty queue hands the arrival straight through.
   assign avail    = (fill_ff != '0) || push_w;
   assign front_id = (fill_ff == '0) ? push_id : head_id_ff;
   assign fill     = fill_ff;

   always_comb begin
      tail_in = tail_ff;
      head_in = head_ff;
      if (push_w) begin
         tail_in = (tail_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(tail_ff + 1'b1);
      end
      if (ctrl.pop) begin
         head_in = (head_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(head_ff + 1'b1);
      end
      fill_in = FW'(fill_ff + FW'(push_w) - FW'(ctrl.pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_w) begin
         mem[tail_ff] <= push_id;
      end
   end

   // Prefetch the next head; bypass a write landing on it this cycle.
   always_ff @(posedge clock) begin
      if (push_w && (tail_ff == head_in)) begin
         head_id_ff <= push_id;
      end else begin
         head_id_ff <= mem[head_in];
      end
   end

endmodule

/* rtl/olda_section.sv */
// Shared section: ordered holding line, oldest entry leaves first.
`timescale 1ns / 1ps

module olda_section
   import olda_pkg::*;
#(
   parameter int SECTION_SLOTS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  section_ctrl_type                     ctrl,
   input  logic [ID_W-1:0]                      enter_id,
   output logic [ID_W-1:0]                      front_id,
   output logic [$clog2(SECTION_SLOTS+1)-1:0]   count
);

   localparam int CW  = $clog2(SECTION_SLOTS + 1);
   localparam int SIW = (SECTION_SLOTS > 1) ? $clog2(SECTION_SLOTS) : 1;

   logic [ID_W-1:0] slot_ff [SECTION_SLOTS];
   logic [ID_W-1:0] slot_in [SECTION_SLOTS];
   logic [ID_W-1:0] shifted [SECTION_SLOTS];
   logic [CW-1:0]   count_ff, count_in, count_left;
   logic [SIW-1:0]  wr_idx;

   assign front_id   = slot_ff[0];
   assign count      = count_ff;
   assign count_left = CW'(count_ff - CW'(ctrl.leave));
   assign wr_idx     = SIW'(count_left);
   assign count_in   = CW'(count_left + CW'(ctrl.enter));

   always_comb begin
      for (int i = 0; i < SECTION_SLOTS - 1; i++) begin
         shifted[i] = slot_ff[i + 1];
      end
      shifted[SECTION_SLOTS - 1] = slot_ff[SECTION_SLOTS - 1];
      for (int i = 0; i < SECTION_SLOTS; i++) begin
         slot_in[i] = ctrl.leave ? shifted[i] : slot_ff[i];
         if (ctrl.enter && (wr_idx == SIW'(i))) begin
            slot_in[i] = enter_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SECTION_SLOTS; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

endmodule
